[rtl/quadratic_easing_curve_eval_macros.svh]
// Assertion helpers used by the top-level design file.
`ifndef QUADRATIC_EASING_CURVE_EVAL_MACROS_SVH
`define QUADRATIC_EASING_CURVE_EVAL_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define QEC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked on the next clock edge, outside reset.
`define QEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/qec_pkg.sv]
package qec_pkg;

   // Default number of fraction bits; one equals 2^FRAC_BITS.
   localparam int unsigned DEF_FRAC_BITS = 16;

endpackage

[rtl/qec_sqrt_cell.sv]
// One stage of the restoring square root: settles one root bit per cycle while advance is high.
module qec_sqrt_cell import qec_pkg::*; #(
   parameter int unsigned RW = 36,
   parameter int unsigned SW = 18,
   parameter int unsigned STEP = 0
) (
   input  logic          clock,
   input  logic          advance,
   input  logic [RW-1:0] rem_i,
   input  logic [SW-1:0] root_i,
   output logic [RW-1:0] rem_o,
   output logic [SW-1:0] root_o
);

   // Root bit settled by this stage.
   localparam int unsigned K = SW - 1 - STEP;

   logic [RW+1:0] trial;
   logic [RW+1:0] rem_ext;
   logic [RW-1:0] rem_in;
   logic [SW-1:0] root_in;
   logic [RW-1:0] rem_ff;
   logic [SW-1:0] root_ff;

   // Trial subtract of (r + 2^k)^2 - r^2, that is (2r + 2^k) * 2^k.
   always_comb begin
      rem_ext = {2'b00, rem_i};
      trial = (({2'b00, {(RW-SW){1'b0}}, root_i} << 1) | ((RW+2)'(1) << K)) << K;
      if (rem_ext >= trial) begin
         rem_in = RW'(rem_ext - trial);
         root_in = root_i | (SW'(1) << K);
      end else begin
         rem_in = rem_i;
         root_in = root_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rem_o = rem_ff;
   assign root_o = root_ff;

endmodule

[rtl/qec_div_cell.sv]
// One stage of the restoring divider: settles one quotient bit per cycle while advance is high.
module qec_div_cell import qec_pkg::*; #(
   parameter int unsigned DW = 19,
   parameter int unsigned QW = 18
) (
   input  logic          clock,
   input  logic          advance,
   input  logic [DW-1:0] rem_i,
   input  logic [DW-1:0] den_i,
   input  logic [QW-1:0] quo_i,
   output logic [DW-1:0] rem_o,
   output logic [QW-1:0] quo_o
);

   logic [DW:0]   shifted;
   logic [DW-1:0] rem_in;
   logic [QW-1:0] quo_in;
   logic [DW-1:0] rem_ff;
   logic [QW-1:0] quo_ff;

   // Shift in a zero, then subtract the divisor when it fits.
   always_comb begin
      shifted = {rem_i, 1'b0};
      if (shifted >= {1'b0, den_i}) begin
         rem_in = DW'(shifted - {1'b0, den_i});
         quo_in = {quo_i[QW-2:0], 1'b1};
      end else begin
         rem_in = DW'(shifted);
         quo_in = {quo_i[QW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign rem_o = rem_ff;
   assign quo_o = quo_ff;

endmodule

[rtl/quadratic_easing_curve_eval.sv]
// Channel  Direction  tdata fields (low bit up)               tuser
// req      in         curve_a[16:0] curve_b[16:0] position    linear_bypass
// rsp      out        curve_value                             used_linear
//
// The pipeline holds FRAC_BITS+2 square root cells, FRAC_BITS divider
// cells and seven further registers.
// A new word is taken every cycle unless the output stalls. Reset clears only the valid bits.
// A stalled result freezes the whole pipeline; the output register holds.
`include "quadratic_easing_curve_eval_macros.svh"
module quadratic_easing_curve_eval import qec_pkg::*; #(
   parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // curve_a, curve_b, position from bit 0 up, zero filled to bytes
   input  logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0] req_tdata,
   // linear_bypass
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // curve_value, zero filled to bytes
   output logic [((FRAC_BITS+1+7)/8)*8-1:0] rsp_tdata,
   // used_linear
   output logic rsp_tuser
);

   localparam int unsigned FW = FRAC_BITS + 1;
   localparam int unsigned OW = ((FW + 7) / 8) * 8;
   localparam int unsigned RW = 2 * FW + 2;
   localparam int unsigned SW = FW + 1;
   localparam int unsigned DW = FW + 3;
   localparam int unsigned QW = FW + 1;
   localparam int unsigned NS = SW;
   localparam int unsigned ND = FRAC_BITS;
   localparam int unsigned LAT = 1 + NS + 1 + ND + 4;
   localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;
   localparam logic [FW-1:0] HALF = FW'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      logic          lin;
      logic [FW-1:0] a;
      logic [FW-1:0] b;
      logic [FW-1:0] x;
   } item_type;

   logic          adv;
   logic [LAT-1:0] vld_ff;
   logic          out_vld_ff;
   logic [FW-1:0] out_val_ff;
   logic          out_lin_ff;

   // The pipe moves whenever the output register is free or drains.
   assign adv = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   function automatic logic [FW-1:0] lim(input logic [FW-1:0] v);
      lim = (v > ONE) ? ONE : v;
   endfunction

   // Stage 0: clamp inputs, form |a-x| and x(1-x).
   item_type       s0_ff;
   logic [FW-1:0]  d0_ff;
   logic [RW-1:0]  xx0_ff;
   item_type       s0_in;
   always_comb begin
      s0_in.a = lim(req_tdata[FW-1:0]);
      s0_in.b = lim(req_tdata[2*FW-1:FW]);
      s0_in.x = lim(req_tdata[3*FW-1:2*FW]);
      s0_in.lin = req_tuser || (s0_in.a == HALF);
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff <= s0_in;
         d0_ff <= (s0_in.a > s0_in.x) ? s0_in.a - s0_in.x : s0_in.x - s0_in.a;
         xx0_ff <= RW'(s0_in.x) * RW'(ONE - s0_in.x);
      end
   end

   // Stage 1: discriminant.
   item_type      s1_ff;
   logic [RW-1:0] disc_ff;
   logic          corner_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s0_ff;
         disc_ff <= RW'(d0_ff) * RW'(d0_ff) + xx0_ff;
         corner_ff <= (d0_ff == ONE);
      end
   end

   // Square root chain with the item riding alongside.
   logic [RW-1:0] srem [NS+1];
   logic [SW-1:0] sroot [NS+1];
   item_type      sitm_ff [NS];
   logic          scor_ff [NS];
   assign srem[0] = disc_ff;
   assign sroot[0] = '0;
   for (genvar i = 0; i < NS; i++) begin : g_sqrt
      qec_sqrt_cell #(.RW(RW), .SW(SW), .STEP(i)) u_cell (
         .clock(clock), .advance(adv),
         .rem_i(srem[i]), .root_i(sroot[i]),
         .rem_o(srem[i+1]), .root_o(sroot[i+1])
      );
      always_ff @(posedge clock) begin
         if (adv) begin
            sitm_ff[i] <= (i == 0) ? s1_ff : sitm_ff[(i == 0) ? 0 : i-1];
            scor_ff[i] <= (i == 0) ? corner_ff : scor_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   // Denominator a + s (s taken as one at the corner); first quotient bit.
   item_type      s2_ff;
   logic [DW-1:0] den_ff;
   logic [DW-1:0] r2_ff;
   logic          q2_ff;
   logic [DW-1:0] den2;
   always_comb begin
      den2 = DW'(sitm_ff[NS-1].a) +
         (scor_ff[NS-1] ? DW'(ONE) : DW'(sroot[NS]));
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff <= sitm_ff[NS-1];
         den_ff <= den2;
         q2_ff <= (DW'(sitm_ff[NS-1].x) >= den2) && (den2 != '0);
         r2_ff <= (DW'(sitm_ff[NS-1].x) >= den2 && den2 != '0) ?
            DW'(sitm_ff[NS-1].x) - den2 : DW'(sitm_ff[NS-1].x);
      end
   end

   // Divider chain; the divisor and item travel with each word.
   logic [DW-1:0] drem [ND+1];
   logic [QW-1:0] dquo [ND+1];
   item_type      ditm_ff [ND];
   logic [DW-1:0] dden_ff [ND];
   assign drem[0] = r2_ff;
   assign dquo[0] = QW'(q2_ff);
   for (genvar j = 0; j < ND; j++) begin : g_div
      logic [DW-1:0] den_use;
      assign den_use = (j == 0) ? den_ff : dden_ff[(j == 0) ? 0 : j-1];
      if (j < ND - 1) begin : g_q
         qec_div_cell #(.DW(DW), .QW(QW)) u_cell (
            .clock(clock), .advance(adv),
            .rem_i(drem[j]), .den_i(den_use), .quo_i(dquo[j]),
            .rem_o(drem[j+1]), .quo_o(dquo[j+1])
         );
      end else begin : g_last
         qec_div_cell #(.DW(DW), .QW(QW)) u_cell (
            .clock(clock), .advance(adv),
            .rem_i(drem[j]), .den_i(den_use), .quo_i(dquo[j]),
            .rem_o(drem[j+1]), .quo_o(dquo[j+1])
         );
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            ditm_ff[j] <= (j == 0) ? s2_ff : ditm_ff[(j == 0) ? 0 : j-1];
            dden_ff[j] <= den_use;
         end
      end
   end

   // Quotient limit (zero divisor gives zero), then u*b.
   item_type          s3_ff;
   logic [FW-1:0]     t3_ff;
   item_type          s4_ff;
   logic [FW-1:0]     t4_ff;
   logic [2*FW-1:0]   ub4_ff;
   item_type          s5_ff;
   logic [FW-1:0]     t5_ff;
   logic [FW+1:0]     w5_ff;
   logic [FW-1:0]     f6;
   logic [FW+FW+1:0]  tw;
   logic              dz;
   assign dz = (dden_ff[ND-1] == '0);
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ff <= ditm_ff[ND-1];
         t3_ff <= dz ? '0 : ((dquo[ND] > QW'(ONE)) ? ONE : FW'(dquo[ND]));
         s4_ff <= s3_ff;
         t4_ff <= t3_ff;
         ub4_ff <= (2*FW)'(ONE - t3_ff) * (2*FW)'(s3_ff.b);
         s5_ff <= s4_ff;
         t5_ff <= t4_ff;
         w5_ff <= (FW+2)'({ub4_ff >> FRAC_BITS, 1'b0}) + (FW+2)'(t4_ff);
      end
   end

   // Final t*w, limit and output register (position passed through when linear).
   always_comb begin
      tw = (2*FW+2)'(t5_ff) * (2*FW+2)'(w5_ff);
      f6 = ((tw >> FRAC_BITS) > (2*FW+2)'(ONE)) ? ONE : FW'(tw >> FRAC_BITS);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[LAT-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         out_val_ff <= s5_ff.lin ? s5_ff.x : f6;
         out_lin_ff <= s5_ff.lin;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = OW'(out_val_ff);
   assign rsp_tuser = out_lin_ff;

   `QEC_ASSERT_IMP(a_val_range, clock, reset, rsp_tvalid, out_val_ff <= ONE, "value above one")
   `QEC_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled word changed")
   `QEC_ASSERT_IMP(a_ready, clock, reset, !rsp_tvalid, req_tready, "pipe stalled with empty output")

endmodule
